// ===== src/assert_macros.svh =====
// assertion helpers for the checker file mpht_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define MPHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MPHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/mpht_pkg.sv =====
`default_nettype none

package mpht_pkg;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // fixed field widths
    localparam int INODE_W    = 64;
    localparam int FS_W       = 32;
    localparam int NS_IN_W    = 4;
    localparam int ENTRY_IN_W = 6;

    // pearson permutation
    localparam logic [7:0] PEARSON_PERM [256] = '{
        8'd14,  8'd132, 8'd225, 8'd182, 8'd47,  8'd210, 8'd44,  8'd79,
        8'd83,  8'd145, 8'd5,   8'd135, 8'd192, 8'd162, 8'd205, 8'd91,
        8'd29,  8'd55,  8'd48,  8'd152, 8'd246, 8'd12,  8'd117, 8'd104,
        8'd211, 8'd119, 8'd49,  8'd206, 8'd36,  8'd72,  8'd24,  8'd3,
        8'd227, 8'd9,   8'd41,  8'd239, 8'd250, 8'd61,  8'd164, 8'd200,
        8'd247, 8'd184, 8'd108, 8'd161, 8'd99,  8'd185, 8'd230, 8'd126,
        8'd96,  8'd70,  8'd163, 8'd170, 8'd77,  8'd15,  8'd43,  8'd81,
        8'd76,  8'd187, 8'd52,  8'd180, 8'd178, 8'd80,  8'd86,  8'd253,
        8'd141, 8'd105, 8'd157, 8'd168, 8'd93,  8'd196, 8'd193, 8'd13,
        8'd232, 8'd125, 8'd115, 8'd183, 8'd127, 8'd51,  8'd129, 8'd222,
        8'd113, 8'd251, 8'd121, 8'd101, 8'd20,  8'd169, 8'd94,  8'd197,
        8'd229, 8'd151, 8'd218, 8'd95,  8'd114, 8'd64,  8'd124, 8'd208,
        8'd147, 8'd0,   8'd27,  8'd103, 8'd50,  8'd189, 8'd252, 8'd238,
        8'd107, 8'd173, 8'd130, 8'd235, 8'd106, 8'd33,  8'd167, 8'd30,
        8'd156, 8'd237, 8'd140, 8'd57,  8'd214, 8'd249, 8'd155, 8'd143,
        8'd78,  8'd39,  8'd203, 8'd171, 8'd2,   8'd242, 8'd219, 8'd177,
        8'd215, 8'd216, 8'd54,  8'd23,  8'd191, 8'd34,  8'd84,  8'd69,
        8'd244, 8'd176, 8'd45,  8'd241, 8'd174, 8'd158, 8'd179, 8'd6,
        8'd153, 8'd65,  8'd149, 8'd68,  8'd85,  8'd195, 8'd112, 8'd234,
        8'd42,  8'd25,  8'd58,  8'd254, 8'd102, 8'd92,  8'd100, 8'd82,
        8'd220, 8'd236, 8'd1,   8'd110, 8'd56,  8'd63,  8'd194, 8'd136,
        8'd16,  8'd223, 8'd139, 8'd209, 8'd35,  8'd37,  8'd40,  8'd87,
        8'd148, 8'd199, 8'd201, 8'd233, 8'd217, 8'd255, 8'd59,  8'd146,
        8'd207, 8'd190, 8'd116, 8'd32,  8'd7,   8'd4,   8'd98,  8'd154,
        8'd97,  8'd134, 8'd60,  8'd46,  8'd38,  8'd138, 8'd22,  8'd204,
        8'd175, 8'd172, 8'd17,  8'd73,  8'd133, 8'd142, 8'd10,  8'd213,
        8'd240, 8'd11,  8'd228, 8'd66,  8'd131, 8'd224, 8'd118, 8'd74,
        8'd181, 8'd160, 8'd19,  8'd159, 8'd31,  8'd53,  8'd248, 8'd120,
        8'd88,  8'd71,  8'd90,  8'd137, 8'd166, 8'd165, 8'd21,  8'd212,
        8'd122, 8'd231, 8'd226, 8'd18,  8'd123, 8'd128, 8'd109, 8'd221,
        8'd144, 8'd186, 8'd28,  8'd243, 8'd75,  8'd26,  8'd188, 8'd67,
        8'd8,   8'd89,  8'd202, 8'd111, 8'd150, 8'd198, 8'd245, 8'd62
    };

endpackage

`default_nettype wire

// ===== src/mpht_hash.sv =====
`default_nettype none

module mpht_hash
    import mpht_pkg::*;
#(
    parameter int BUCKETS_PER_NAMESPACE = 16,
    parameter int BKT_W = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [INODE_W-1:0] i_inode,
    output logic                    o_done,
    output logic [BKT_W-1:0]        o_bucket
);

    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_cnt;
    logic [7:0]         r_h;
    logic [INODE_W-1:0] r_key;
    logic [BKT_W-1:0]   bkt_tab [256];

    // hash value to bucket, worked out at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_bkt
        localparam int BV = g % BUCKETS_PER_NAMESPACE;
        assign bkt_tab[g] = BKT_W'(BV);
    end

    // one byte per cycle, least significant byte first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // hash datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_inode;
            r_h   <= 8'd0;
        end else if (r_busy) begin
            r_key <= r_key >> 8;
            r_h   <= PEARSON_PERM[r_h ^ r_key[7:0]];
        end
    end

    assign o_done   = r_done;
    assign o_bucket = bkt_tab[r_h];

endmodule

`default_nettype wire

// ===== src/mount_point_hash_table_top.sv =====
// flow: an accepted item runs through the 8-step pearson hash unit and a bucket head read;
//   an insert then writes one pool entry, a lookup walks its chain one pool entry at a time
// ordering: one item at a time; input stays stalled from an accept until its result
//   is passed to the output register
// reset: sync, active low; a clearing pass over all NUM_NAMESPACES * BUCKETS_PER_NAMESPACE
//   bucket slots (256 by default) follows, with input stalled
`default_nettype none

module mount_point_hash_table_top
    import mpht_pkg::*;
#(
    parameter int NUM_NAMESPACES        = 16,
    parameter int POOL_ENTRIES          = 64,
    parameter int BUCKETS_PER_NAMESPACE = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_mode,
    input  wire logic [NS_IN_W-1:0]    i_namespace_index,
    input  wire logic [INODE_W-1:0]    i_inode,
    input  wire logic [FS_W-1:0]       i_enclosing_filesystem,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_status,
    output logic [ENTRY_IN_W-1:0]      o_entry_index,
    output logic                       o_became_root
);

    localparam int SLOTS  = NUM_NAMESPACES * BUCKETS_PER_NAMESPACE;
    localparam int NS_W   = (NUM_NAMESPACES > 1) ? $clog2(NUM_NAMESPACES) : 1;
    localparam int BKT_W  = (BUCKETS_PER_NAMESPACE > 1) ? $clog2(BUCKETS_PER_NAMESPACE) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PIDX_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);

    typedef struct packed {
        logic              valid;
        logic [PIDX_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic [INODE_W-1:0] inode;
        logic [FS_W-1:0]    fs;
        t_link              next;
    } t_entry;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_HASH   = 8'b0000_0100,
        S_RDHEAD = 8'b0000_1000,
        S_HEAD   = 8'b0001_0000,
        S_WALK   = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [SLOT_W-1:0]         r_clr;
    logic                      r_mode;
    logic [NS_W-1:0]           r_ns;
    logic [INODE_W-1:0]        r_inode;
    logic [FS_W-1:0]           r_fs;
    logic [SLOT_W-1:0]         r_slot;
    logic [PIDX_W-1:0]         r_cur;
    logic [CNT_W-1:0]          r_count;
    logic [NUM_NAMESPACES-1:0] r_root_valid;
    logic [1:0]                r_res_status;
    logic [PIDX_W-1:0]         r_res_idx;
    logic                      r_res_root;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [ENTRY_IN_W-1:0]     r_out_idx;
    logic                      r_out_root;
    t_link                     r_bkt_q;
    t_entry                    r_pool_q;

    t_link                     bkt_mem  [SLOTS];
    t_entry                    pool_mem [POOL_ENTRIES];

    logic [NS_W-1:0]           ns_tab [16];
    logic                      accept_in;
    logic                      hash_done;
    logic [BKT_W-1:0]          hash_bucket;
    logic                      pool_full;
    logic                      key_match;
    logic                      out_free;
    logic                      bkt_we;
    logic                      bkt_re;
    logic [SLOT_W-1:0]         bkt_waddr;
    t_link                     bkt_wdata;
    logic                      pool_we;
    logic                      pool_re;
    logic [PIDX_W-1:0]         pool_raddr;
    t_entry                    pool_wdata;
    logic                      res_load;
    logic [1:0]                res_status;
    logic [PIDX_W-1:0]         res_idx;
    logic                      res_root;
    logic                      root_set;
    logic                      count_inc;

    // namespace index wraps modulo the namespace count
    for (genvar v = 0; v < 16; v++) begin : g_ns
        localparam int NSV = v % NUM_NAMESPACES;
        assign ns_tab[v] = NS_W'(NSV);
    end

    assign accept_in  = i_in_valid && r_state == S_IDLE;
    assign o_in_stall = r_state != S_IDLE;
    assign pool_full  = r_count == CNT_W'(POOL_ENTRIES);
    assign key_match  = r_pool_q.inode == r_inode && r_pool_q.fs == r_fs;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign bkt_re     = r_state == S_RDHEAD;

    mpht_hash #(
        .BUCKETS_PER_NAMESPACE(BUCKETS_PER_NAMESPACE),
        .BKT_W(BKT_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept_in),
        .i_inode (i_inode),
        .o_done  (hash_done),
        .o_bucket(hash_bucket)
    );

    // sequencer and memory port control
    always_comb begin
        n_state          = r_state;
        bkt_we           = 1'b0;
        bkt_waddr        = r_slot;
        bkt_wdata        = '0;
        pool_we          = 1'b0;
        pool_wdata.inode = r_inode;
        pool_wdata.fs    = r_fs;
        pool_wdata.next  = r_bkt_q;
        pool_re          = 1'b0;
        pool_raddr       = r_bkt_q.idx;
        res_load         = 1'b0;
        res_status       = ST_OK;
        res_idx          = '0;
        res_root         = 1'b0;
        root_set         = 1'b0;
        count_inc        = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                if (r_clr == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_RDHEAD;
                end
            end
            S_RDHEAD: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = S_DONE;
                if (r_mode == MODE_INSERT) begin
                    res_load = 1'b1;
                    if (pool_full) begin
                        res_status = ST_FULL;
                    end else begin
                        pool_we   = 1'b1;
                        count_inc = 1'b1;
                        res_idx   = r_count[PIDX_W-1:0];
                        if (!r_root_valid[r_ns]) begin
                            // empty root slot takes the entry, chain untouched
                            pool_wdata.next = '0;
                            root_set        = 1'b1;
                            res_root        = 1'b1;
                        end else begin
                            // push onto the bucket head
                            bkt_we          = 1'b1;
                            bkt_wdata.valid = 1'b1;
                            bkt_wdata.idx   = r_count[PIDX_W-1:0];
                        end
                    end
                end else if (r_bkt_q.valid) begin
                    pool_re = 1'b1;
                    n_state = S_WALK;
                end else begin
                    res_load   = 1'b1;
                    res_status = ST_NOT_FOUND;
                end
            end
            S_WALK: begin
                if (key_match) begin
                    res_load = 1'b1;
                    res_idx  = r_cur;
                    n_state  = S_DONE;
                end else if (r_pool_q.next.valid) begin
                    pool_re    = 1'b1;
                    pool_raddr = r_pool_q.next.idx;
                end else begin
                    res_load   = 1'b1;
                    res_status = ST_NOT_FOUND;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_count      <= '0;
            r_root_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (count_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (root_set) begin
                r_root_valid[r_ns] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_mode  <= i_mode;
            r_ns    <= ns_tab[i_namespace_index];
            r_inode <= i_inode;
            r_fs    <= i_enclosing_filesystem;
        end
        if (r_state == S_HASH && hash_done) begin
            r_slot <= SLOT_W'(r_ns) * SLOT_W'(BUCKETS_PER_NAMESPACE) + SLOT_W'(hash_bucket);
        end
        if (pool_re) begin
            r_cur <= pool_raddr;
        end
        if (res_load) begin
            r_res_status <= res_status;
            r_res_idx    <= res_idx;
            r_res_root   <= res_root;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_idx    <= ENTRY_IN_W'(r_res_idx);
            r_out_root   <= r_res_root;
        end
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re) begin
            r_bkt_q <= bkt_mem[r_slot];
        end
    end

    // entry pool memory, filled in index order
    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            pool_mem[r_count[PIDX_W-1:0]] <= pool_wdata;
        end
        if (pool_re) begin
            r_pool_q <= pool_mem[pool_raddr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_became_root = r_out_root;

endmodule

`default_nettype wire

// ===== src/mpht_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mpht_checker
    import mpht_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [1:0]            o_status,
    input wire logic [ENTRY_IN_W-1:0] o_entry_index,
    input wire logic                  o_became_root
);

    logic                  in_accept;
    logic                  out_held;
    logic                  out_fail;
    logic [ENTRY_IN_W+2:0] out_item;

    // handshake and result item as seen on the ports
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_fail  = o_out_valid && o_status != ST_OK;
    assign out_item  = {o_status, o_entry_index, o_became_root};

    // a stalled result item holds
    `MPHT_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(out_item), "stalled item changed")

    // one item at a time: input stalls right after an accept
    `MPHT_ASSERT(a_one_at_a_time, in_accept |=> o_in_stall, "input not stalled after accept")

    // failed items carry no entry and never report a root fill
    `MPHT_ASSERT(a_fail_clean, out_fail |-> out_item[ENTRY_IN_W:0] == '0, "failed item has entry")

    // a new result only follows a busy period
    `MPHT_ASSERT(a_res_after_work, $rose(o_out_valid) |-> $past(o_in_stall), "result without work")

endmodule

bind mount_point_hash_table_top mpht_checker u_mpht_checker (.*);

`default_nettype wire
